### rtl/core/char_lcd_4bit_interface_top_macros.svh
// Assertion macros used by the checker file of the character LCD controller.
`ifndef CHAR_LCD_4BIT_INTERFACE_TOP_MACROS_SVH
`define CHAR_LCD_4BIT_INTERFACE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLCD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clcd check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CLCD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clcd check failed: next-cycle implication");

`endif

### rtl/core/clcd_pkg.sv
// Package with shared types, constants and tables of the character LCD controller.
`default_nettype none
package clcd_pkg;

	localparam int TIMER_WIDTH_DEF = 20;
	localparam int CFG_WIDTH = 20;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam logic [CFG_WIDTH-1:0] POWER_ON_WAIT_RST = 20'd100000;
	localparam logic [CFG_WIDTH-1:0] INIT_PULSE_WAIT_RST = 20'd5000;
	localparam logic [CFG_WIDTH-1:0] ENABLE_HIGH_TIME_RST = 20'd50;
	localparam logic [CFG_WIDTH-1:0] DATA_SETTLE_TIME_RST = 20'd50;
	localparam logic [CFG_WIDTH-1:0] COMMAND_SETTLE_TIME_RST = 20'd5000;
	localparam logic [CFG_WIDTH-1:0] NIBBLE_SETUP_TIME_RST = 20'd100000;

	localparam logic [2:0] REG_POWER_ON_WAIT = 3'd0;
	localparam logic [2:0] REG_INIT_PULSE_WAIT = 3'd1;
	localparam logic [2:0] REG_ENABLE_HIGH_TIME = 3'd2;
	localparam logic [2:0] REG_DATA_SETTLE_TIME = 3'd3;
	localparam logic [2:0] REG_COMMAND_SETTLE_TIME = 3'd4;
	localparam logic [2:0] REG_NIBBLE_SETUP_TIME = 3'd5;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_COMMAND = 2'd1;
	localparam logic [1:0] ACT_DATA = 2'd2;
	localparam logic [1:0] ACT_POSITION = 2'd3;

	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] power_on_wait;
		logic [CFG_WIDTH-1:0] init_pulse_wait;
		logic [CFG_WIDTH-1:0] enable_high_time;
		logic [CFG_WIDTH-1:0] data_settle_time;
		logic [CFG_WIDTH-1:0] command_settle_time;
		logic [CFG_WIDTH-1:0] nibble_setup_time;
	} cfg_t;

	typedef struct packed {
		logic       init_done;
		logic       rejected;
		logic       busy_res;
		logic [3:0] data_nibble;
		logic       en_level;
		logic       rs_level;
	} result_t;

	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h28;
			3'd1: c = 8'h08;
			3'd2: c = 8'h01;
			3'd3: c = 8'h06;
			3'd4: c = 8'h0C;
			default: c = 8'h0C;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] row_offset(input logic [1:0] row);
		logic [7:0] o;
		case (row)
			2'd0: o = 8'h00;
			2'd1: o = 8'h40;
			2'd2: o = 8'h60;
			default: o = 8'h20;
		endcase
		return o;
	endfunction

endpackage
`default_nettype wire

### rtl/core/char_lcd_4bit_interface_top.sv
// Top level of the 4-bit character LCD controller.
// Request words enter on the s_axis channel: tuser carries the action (tick, command byte,
// data byte, set position) and tdata the byte, column and row. Every accepted word gives
// exactly one result word on the m_axis channel with the bus line levels (rs, en, four data
// lines), busy, rejected and init-done flags as they stand after that word.
// A word is registered at acceptance and applied to the sequencer once the result register
// is free, which loads the sequencer state; the state update is a single sequencer pass.
// One word per cycle is sustained while the receiver takes each result.
// After reset the controller is busy and runs the power-on sequence, paced by tick words;
// command, data and position words that arrive while busy are answered with rejected set.
// APB-written timing registers act on the next timer load, but power_on_wait is never read.
// If the receiver stalls, the result holds, one further word is taken into the input
// register, and s_axis_tready then drops until the result is taken.
`default_nettype none
module char_lcd_4bit_interface_top #(
	parameter int TIMER_WIDTH = clcd_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Bits from low: byte_value[7:0], column[12:8], row[14:13], zero [15].
	input  wire logic [15:0]                      s_axis_tdata,
	// Bits from low: action[1:0].
	input  wire logic [1:0]                       s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// Bits from low: rs_level[0], en_level[1], data_nibble[5:2], busy_res[6],
	// rejected[7], init_done[8], zero [15:9].
	output logic [15:0]                           m_axis_tdata,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [clcd_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [clcd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [clcd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready
);

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [7:0]  byte_s1;
	logic [4:0]  column_s1;
	logic [1:0]  row_s1;
	logic        out_valid_q;
	logic        step;
	clcd_pkg::cfg_t    cfg;
	clcd_pkg::result_t result;

	assign step = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata[7:0];
			column_s1 <= s_axis_tdata[12:8];
			row_s1 <= s_axis_tdata[14:13];
		end
	end

	clcd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	clcd_seq #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.action     (action_s1),
		.byte_value (byte_s1),
		.column     (column_s1),
		.row        (row_s1),
		.cfg        (cfg),
		.result     (result)
	);

	assign pready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'd0, result};

endmodule
`default_nettype wire

### rtl/core/clcd_cfg.sv
// APB register file holding the six timing registers of the LCD controller.
`default_nettype none
module clcd_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [clcd_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [clcd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [clcd_pkg::APB_DATA_W-1:0]   prdata,
	output clcd_pkg::cfg_t                         cfg
);

	logic [2:0] reg_idx;
	logic       wr_en;
	logic [clcd_pkg::CFG_WIDTH-1:0] wdata;
	logic [clcd_pkg::CFG_WIDTH-1:0] rdata;
	clcd_pkg::cfg_t cfg_q;

	assign reg_idx = paddr[4:2];
	assign wr_en = psel & penable & pwrite;
	assign wdata = pwdata[clcd_pkg::CFG_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_on_wait <= clcd_pkg::POWER_ON_WAIT_RST;
			cfg_q.init_pulse_wait <= clcd_pkg::INIT_PULSE_WAIT_RST;
			cfg_q.enable_high_time <= clcd_pkg::ENABLE_HIGH_TIME_RST;
			cfg_q.data_settle_time <= clcd_pkg::DATA_SETTLE_TIME_RST;
			cfg_q.command_settle_time <= clcd_pkg::COMMAND_SETTLE_TIME_RST;
			cfg_q.nibble_setup_time <= clcd_pkg::NIBBLE_SETUP_TIME_RST;
		end else if (wr_en) begin
			case (reg_idx)
				clcd_pkg::REG_POWER_ON_WAIT: cfg_q.power_on_wait <= wdata;
				clcd_pkg::REG_INIT_PULSE_WAIT: cfg_q.init_pulse_wait <= wdata;
				clcd_pkg::REG_ENABLE_HIGH_TIME: cfg_q.enable_high_time <= wdata;
				clcd_pkg::REG_DATA_SETTLE_TIME: cfg_q.data_settle_time <= wdata;
				clcd_pkg::REG_COMMAND_SETTLE_TIME: cfg_q.command_settle_time <= wdata;
				clcd_pkg::REG_NIBBLE_SETUP_TIME: cfg_q.nibble_setup_time <= wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			clcd_pkg::REG_POWER_ON_WAIT: rdata = cfg_q.power_on_wait;
			clcd_pkg::REG_INIT_PULSE_WAIT: rdata = cfg_q.init_pulse_wait;
			clcd_pkg::REG_ENABLE_HIGH_TIME: rdata = cfg_q.enable_high_time;
			clcd_pkg::REG_DATA_SETTLE_TIME: rdata = cfg_q.data_settle_time;
			clcd_pkg::REG_COMMAND_SETTLE_TIME: rdata = cfg_q.command_settle_time;
			clcd_pkg::REG_NIBBLE_SETUP_TIME: rdata = cfg_q.nibble_setup_time;
			default: rdata = '0;
		endcase
	end

	assign prdata = {{(clcd_pkg::APB_DATA_W-clcd_pkg::CFG_WIDTH){1'b0}}, rdata};
	assign cfg = cfg_q;

endmodule
`default_nettype wire

### rtl/core/clcd_seq.sv
// Bus sequencer of the LCD controller: init sequence, byte transfers and timers.
`default_nettype none
module clcd_seq #(
	parameter int TIMER_WIDTH = clcd_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic [1:0]     action,
	input  wire logic [7:0]     byte_value,
	input  wire logic [4:0]     column,
	input  wire logic [1:0]     row,
	input  wire clcd_pkg::cfg_t cfg,
	output clcd_pkg::result_t   result
);

	localparam logic [3:0] PH_POWER = 4'd0;
	localparam logic [3:0] PH_SETUP = 4'd1;
	localparam logic [3:0] PH_HIGH = 4'd2;
	localparam logic [3:0] PH_SETTLE = 4'd3;
	localparam logic [3:0] PH_IDLE = 4'd4;

	logic [3:0]             phase_q, phase_n;
	logic [TIMER_WIDTH-1:0] cd_q, cd_n, cd_dec;
	logic [3:0]             init_step_q, init_step_n, step_inc;
	logic [7:0]             held_q, held_n;
	logic                   second_q, second_n;
	logic                   is_data_q, is_data_n;
	logic                   rs_q, rs_n;
	logic                   en_q, en_n;
	logic [3:0]             nib_q, nib_n;
	logic                   ready_q, ready_n;
	logic                   rej_q, rej_n;
	logic                   idle;
	logic                   adv;
	logic                   sb_req, sb_data;
	logic [7:0]             sb_byte;
	logic                   raw_req;
	logic [3:0]             raw_nib;

	assign cd_dec = cd_q - 1'b1;
	assign step_inc = init_step_q + 4'd1;
	assign idle = (phase_q >= PH_IDLE);

	always_comb begin
		phase_n = phase_q;
		cd_n = cd_q;
		init_step_n = init_step_q;
		held_n = held_q;
		second_n = second_q;
		is_data_n = is_data_q;
		rs_n = rs_q;
		en_n = en_q;
		nib_n = nib_q;
		ready_n = ready_q;
		rej_n = 1'b0;
		adv = 1'b0;
		sb_req = 1'b0;
		sb_data = 1'b0;
		sb_byte = '0;
		raw_req = 1'b0;
		raw_nib = 4'd3;

		if (action == clcd_pkg::ACT_TICK) begin
			if (!idle) begin
				if (cd_q != '0) begin
					cd_n = cd_dec;
					adv = (cd_dec == '0);
				end else begin
					adv = 1'b1;
				end
			end
		end else if (!idle) begin
			rej_n = 1'b1;
		end else if (action == clcd_pkg::ACT_COMMAND) begin
			sb_req = 1'b1;
			sb_byte = byte_value;
		end else if (action == clcd_pkg::ACT_DATA) begin
			sb_req = 1'b1;
			sb_data = 1'b1;
			sb_byte = byte_value;
		end else if (!column[4]) begin
			sb_req = 1'b1;
			sb_byte = clcd_pkg::CMD_SET_DDRAM | {4'd0, column[3:0]} | clcd_pkg::row_offset(row);
		end

		if (adv) begin
			case (phase_q)
				PH_POWER: begin
					init_step_n = '0;
					raw_req = 1'b1;
				end
				PH_SETUP: begin
					en_n = 1'b1;
					phase_n = PH_HIGH;
					cd_n = TIMER_WIDTH'(cfg.enable_high_time);
				end
				PH_HIGH: begin
					en_n = 1'b0;
					if (!ready_q && init_step_q < 4'd4) begin
						phase_n = PH_SETTLE;
						cd_n = TIMER_WIDTH'(cfg.init_pulse_wait);
					end else if (!second_q) begin
						second_n = 1'b1;
						nib_n = held_q[3:0];
						phase_n = PH_SETUP;
						cd_n = TIMER_WIDTH'(cfg.nibble_setup_time);
					end else begin
						phase_n = PH_SETTLE;
						cd_n = is_data_q ? TIMER_WIDTH'(cfg.data_settle_time)
						                 : TIMER_WIDTH'(cfg.command_settle_time);
					end
				end
				PH_SETTLE: begin
					if (ready_q) begin
						phase_n = PH_IDLE;
					end else begin
						init_step_n = step_inc;
						if (step_inc < 4'd3) begin
							raw_req = 1'b1;
						end else if (step_inc == 4'd3) begin
							raw_req = 1'b1;
							raw_nib = 4'd2;
						end else if (step_inc <= 4'd8) begin
							sb_req = 1'b1;
							sb_byte = clcd_pkg::init_cmd(3'(step_inc - 4'd4));
						end else begin
							init_step_n = 4'd9;
							ready_n = 1'b1;
							phase_n = PH_IDLE;
						end
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end

		if (raw_req) begin
			rs_n = 1'b0;
			en_n = 1'b0;
			nib_n = raw_nib;
			phase_n = PH_SETUP;
			cd_n = '0;
		end
		if (sb_req) begin
			held_n = sb_byte;
			is_data_n = sb_data;
			rs_n = sb_data;
			second_n = 1'b0;
			en_n = 1'b0;
			nib_n = sb_byte[7:4];
			phase_n = PH_SETUP;
			cd_n = TIMER_WIDTH'(cfg.nibble_setup_time);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_POWER;
			cd_q <= TIMER_WIDTH'(clcd_pkg::POWER_ON_WAIT_RST);
			init_step_q <= '0;
			held_q <= '0;
			second_q <= 1'b0;
			is_data_q <= 1'b0;
			rs_q <= 1'b0;
			en_q <= 1'b0;
			nib_q <= '0;
			ready_q <= 1'b0;
			rej_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			cd_q <= cd_n;
			init_step_q <= init_step_n;
			held_q <= held_n;
			second_q <= second_n;
			is_data_q <= is_data_n;
			rs_q <= rs_n;
			en_q <= en_n;
			nib_q <= nib_n;
			ready_q <= ready_n;
			rej_q <= rej_n;
		end
	end

	assign result.rs_level = rs_q;
	assign result.en_level = en_q;
	assign result.data_nibble = nib_q;
	assign result.busy_res = ~idle;
	assign result.rejected = rej_q;
	assign result.init_done = ready_q;

endmodule
`default_nettype wire

### rtl/core/clcd_chk.sv
// Port-level checker of the LCD controller, bound to the top level.
`default_nettype none
`include "char_lcd_4bit_interface_top_macros.svh"
module clcd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);

	// A dropped request leaves the controller busy.
	`CLCD_ASSERT_IMP(a_rej_busy, clk, arst_n, m_axis_tvalid && m_axis_tdata[7], m_axis_tdata[6])
	// Enable is only driven high in the middle of a transfer.
	`CLCD_ASSERT_IMP(a_en_busy, clk, arst_n, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[6])
	// Once the init sequence has finished it never reports unfinished again.
	`CLCD_ASSERT_NXT(a_done_kept, clk, arst_n, m_axis_tvalid && m_axis_tready && m_axis_tdata[8], !m_axis_tvalid || m_axis_tdata[8])
	// A stalled result word holds.
	`CLCD_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind char_lcd_4bit_interface_top clcd_chk u_clcd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
